### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define A_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define A_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define A_IMPL(lbl, clk, rst_n, ante, cons)
`define A_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/uvsp_pkg.sv
// Package for the stereographic projection block: payload types, constants, atan table.
// No dependencies.
`default_nettype none
package uvsp_pkg;
    localparam int COMP_BITS    = 16;
    localparam int STAGES       = 16;
    localparam int MAX_STAGES   = 32;
    localparam int THR_BITS     = 15;
    localparam logic [THR_BITS-1:0] THR_RESET = 15'd1;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] vec_x;
        logic signed [COMP_BITS-1:0] vec_y;
        logic signed [COMP_BITS-1:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] azimuth;
        logic [14:0]        radius;
        logic               is_vertical;
        logic               was_flipped;
    } t_out;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t [0:31];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
              32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
              32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return t[i[4:0]];
    endfunction
endpackage
`default_nettype wire

### hdl/uvsp_lanes.sv
// Generic pipeline of 1-bit-per-stage units: CORDIC atan2 and square root.
// Uses uvsp_pkg; instantiated by the top level.
`default_nettype none
module uvsp_lanes #(
    parameter int CB = uvsp_pkg::COMP_BITS,
    parameter int NS = uvsp_pkg::STAGES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CB-1:0] i_x,
    input  wire logic signed [CB-1:0] i_y,
    input  wire logic        [CB-1:0] i_az,
    input  wire logic [uvsp_pkg::THR_BITS-1:0] i_thr,
    input  wire logic                 i_flip,
    output logic                      o_valid,
    output logic [31:0]               o_ang,
    output logic [CB-1:0]             o_h,
    output logic [CB:0]               o_den,
    output logic                      o_vert,
    output logic                      o_flip,
    output logic                      o_nz
);
    localparam int NC  = (NS > uvsp_pkg::MAX_STAGES) ? uvsp_pkg::MAX_STAGES : NS;
    localparam int SQ  = CB;            // one root bit per stage
    localparam int W   = CB + 3;        // CORDIC datapath width
    localparam int RW  = 2*CB;          // radicand width, two bits per root bit
    localparam int L   = (NC > SQ) ? NC : SQ;

    // per-stage registers
    logic                 r_v    [0:L];
    logic signed [W-1:0]  r_cx   [0:L];
    logic signed [W-1:0]  r_cy   [0:L];
    logic [31:0]          r_ang  [0:L];
    logic [RW-1:0]        r_rem  [0:L];
    logic [RW-1:0]        r_rad  [0:L];
    logic [CB-1:0]        r_root [0:L];
    logic [CB:0]          r_den  [0:L];
    logic                 r_flip [0:L];
    logic                 r_nz   [0:L];
    logic [uvsp_pkg::THR_BITS-1:0] r_thr [0:L];

    logic [CB-1:0] ax, ay;
    logic [2*CB-1:0] sx2, sy2;

    // stage 0: fold to right half plane, form x^2+y^2
    always_comb begin
        ax  = i_x[CB-1] ? CB'(-i_x) : i_x;
        ay  = i_y[CB-1] ? CB'(-i_y) : i_y;
        sx2 = ax * ax;
        sy2 = ay * ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            if (i_y[CB-1]) begin
                r_cx[0]  <= -W'(i_y);
                r_cy[0]  <= -W'(i_x);
                r_ang[0] <= 32'h80000000;
            end else begin
                r_cx[0]  <= W'(i_y);
                r_cy[0]  <= W'(i_x);
                r_ang[0] <= 32'h0;
            end
            r_rad[0]  <= RW'(sx2) + RW'(sy2);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_den[0]  <= ((CB+1)'(1) << (CB-1)) + (CB+1)'(i_az);
            r_flip[0] <= i_flip;
            r_nz[0]   <= (i_x != '0) || (i_y != '0);
            r_thr[0]  <= i_thr;
        end
    end

    // stages 1..L: one CORDIC rotation (first NC stages) and one root bit (first SQ stages) each
    for (genvar s = 0; s < L; s++) begin : g_st
        logic signed [W-1:0] n_cx, n_cy;
        logic [31:0]         n_ang;
        logic [RW-1:0]       n_rem, n_rad;
        logic [CB-1:0]       n_root;
        logic [RW-1:0]       trial, rem2;
        always_comb begin
            n_cx = r_cx[s]; n_cy = r_cy[s]; n_ang = r_ang[s];
            if (s < NC) begin
                if (r_cy[s] > 0) begin
                    n_cx  = r_cx[s] + (r_cy[s] >>> s);
                    n_cy  = r_cy[s] - (r_cx[s] >>> s);
                    n_ang = r_ang[s] + uvsp_pkg::atan_turn(s);
                end else begin
                    n_cx  = r_cx[s] - (r_cy[s] >>> s);
                    n_cy  = r_cy[s] + (r_cx[s] >>> s);
                    n_ang = r_ang[s] - uvsp_pkg::atan_turn(s);
                end
            end
            n_rem = r_rem[s]; n_rad = r_rad[s]; n_root = r_root[s];
            rem2 = '0; trial = '0;
            if (s < SQ) begin
                // restoring root: bring down two radicand bits
                rem2  = RW'({r_rem[s], r_rad[s][RW-1:RW-2]});
                n_rad = r_rad[s] << 2;
                trial = RW'({r_root[s], 2'b01});
                if (rem2 >= trial) begin
                    n_rem  = rem2 - trial;
                    n_root = CB'({r_root[s], 1'b1});
                end else begin
                    n_rem  = rem2;
                    n_root = CB'({r_root[s], 1'b0});
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_cx[s+1] <= n_cx; r_cy[s+1] <= n_cy; r_ang[s+1] <= n_ang;
                r_rem[s+1] <= n_rem; r_rad[s+1] <= n_rad; r_root[s+1] <= n_root;
                r_den[s+1] <= r_den[s]; r_flip[s+1] <= r_flip[s];
                r_nz[s+1] <= r_nz[s]; r_thr[s+1] <= r_thr[s];
            end
        end
    end

    logic [CB+15:0] hs, ts;
    always_comb begin
        hs = (CB+16)'(r_root[L]) << 15;
        ts = (CB+16)'(r_thr[L]) << (CB-1);
    end

    assign o_valid = r_v[L];
    assign o_ang   = r_ang[L];
    assign o_h     = r_root[L];
    assign o_den   = r_den[L];
    assign o_vert  = hs < ts;
    assign o_flip  = r_flip[L];
    assign o_nz    = r_nz[L];
endmodule
`default_nettype wire

### hdl/uvsp_div.sv
// Pipelined restoring divider for the radius: (h*2^15 + den/2) / den, saturated.
// Uses uvsp_pkg; instantiated by the top level.
`default_nettype none
module uvsp_div #(
    parameter int CB = uvsp_pkg::COMP_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [CB-1:0] i_h,
    input  wire logic [CB:0]   i_den,
    input  wire uvsp_pkg::t_out i_meta,
    output logic               o_valid,
    output uvsp_pkg::t_out     o_res
);
    // quotient is below 2^17 for any input; 17 stages, saturate after
    localparam int QB = 17;
    localparam int NW = CB + 16;
    localparam int RW = CB + 2;

    logic               r_v    [0:QB];
    logic [NW-1:0]      r_num  [0:QB];
    logic [RW-1:0]      r_rem  [0:QB];
    logic [QB-1:0]      r_q    [0:QB];
    logic [CB:0]        r_den  [0:QB];
    uvsp_pkg::t_out     r_meta [0:QB];
    logic [NW-1:0]      num0;

    // rounded numerator
    assign num0 = (NW'(i_h) << 15) + NW'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_num[0]  <= num0;
            r_rem[0]  <= RW'(num0 >> QB);
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_meta[0] <= i_meta;
        end
    end

    // one quotient bit per stage, from bit QB-1 down
    for (genvar s = 0; s < QB; s++) begin : g_d
        logic [RW-1:0] rem2;
        logic [RW-1:0] n_rem;
        logic          bit_q;
        always_comb begin
            rem2  = RW'({r_rem[s], r_num[s][QB-1-s]});
            bit_q = rem2 >= RW'(r_den[s]);
            n_rem = bit_q ? rem2 - RW'(r_den[s]) : rem2;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_q[s+1]    <= QB'({r_q[s], bit_q});
                r_num[s+1]  <= r_num[s];
                r_den[s+1]  <= r_den[s];
                r_meta[s+1] <= r_meta[s];
            end
        end
    end

    // high numerator bits above QB: numerator < 2^(CB+16), den >= 2^(CB-1),
    // so quotient < 2^17 and the top bits only feed the remainder start
    always_comb begin
        o_res = r_meta[QB];
        if (!r_meta[QB].is_vertical) begin
            o_res.radius = (r_q[QB] > QB'(32767)) ? 15'd32767 : r_q[QB][14:0];
        end
    end
    assign o_valid = r_v[QB];
endmodule
`default_nettype wire

### hdl/unit_vector_stereographic_projection.sv
// A vector passes the lane pipeline, as deep as the larger of COMP_BITS and the CORDIC stages, then the divider.
// Throughput: one vector per cycle; a stall freezes the whole pipeline.
// The output register and pipeline advance together when o_stall is low.
// Synchronous active-low reset clears valid bits; threshold resets to 1.
// Depends on uvsp_pkg, uvsp_lanes, uvsp_div, assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module unit_vector_stereographic_projection #(
    parameter int CORDIC_STAGES  = uvsp_pkg::STAGES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire uvsp_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output uvsp_pkg::t_out      o_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [uvsp_pkg::THR_BITS-1:0] i_cfg_data
);
    localparam int CB = uvsp_pkg::COMP_BITS;

    logic [uvsp_pkg::THR_BITS-1:0] r_thr;
    logic en;
    logic [CB-1:0] az;
    logic l_v, l_vert, l_flip, l_nz;
    logic [31:0] l_ang, ang_f;
    logic [CB-1:0] l_h;
    logic [CB:0] l_den;
    uvsp_pkg::t_out meta;
    logic d_v;
    uvsp_pkg::t_out d_res;

    // whole pipeline moves when the output is not held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= uvsp_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    assign az = i_data.vec_z[CB-1] ? CB'(-i_data.vec_z) : i_data.vec_z;

    uvsp_lanes #(.CB(CB), .NS(CORDIC_STAGES)) u_lanes (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_x(i_data.vec_x), .i_y(i_data.vec_y), .i_az(az), .i_thr(r_thr),
        .i_flip(i_data.vec_z[CB-1]),
        .o_valid(l_v), .o_ang(l_ang), .o_h(l_h), .o_den(l_den),
        .o_vert(l_vert), .o_flip(l_flip), .o_nz(l_nz)
    );

    // fold, round azimuth, zero vertical cases
    always_comb begin
        ang_f = l_nz ? l_ang : 32'h0;
        if (l_flip) ang_f = ang_f + 32'h80000000;
        ang_f = ang_f + 32'h00008000;
        meta.azimuth     = l_vert ? 16'sd0 : ang_f[31:16];
        meta.radius      = '0;
        meta.is_vertical = l_vert;
        meta.was_flipped = l_vert ? 1'b0 : l_flip;
    end

    uvsp_div #(.CB(CB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(l_v),
        .i_h(l_h), .i_den(l_den), .i_meta(meta),
        .o_valid(d_v), .o_res(d_res)
    );

    assign o_valid = d_v;
    assign o_data  = d_res;

    `A_IMPL(a_vert_zero, i_clk, i_rst_n, o_valid && o_data.is_vertical,
        o_data.radius == 15'd0 && o_data.azimuth == 16'sd0 && !o_data.was_flipped)
    `A_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `A_IMPL(a_stall_ties, i_clk, i_rst_n, o_stall, o_valid && i_stall)
endmodule
`default_nettype wire
